FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define FTDT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define FTDT_ASSERT_IMP(label, ante, cons, msg) \
	`FTDT_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define FTDT_ASSERT_NXT(label, ante, cons, msg) \
	`FTDT_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: design/ftdt_pkg.sv
// ----------------------------------------------------------------------------
// ftdt_pkg
// types, constants and microcode table of the float to decimal text unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftdt_pkg;

	localparam int EXP_BIAS   = 127;
	localparam int MANT_BITS  = 23;
	localparam int FRAC_BITS  = 24;
	localparam int INT_BITS   = 31;
	localparam int BCD_DIGITS = 10;
	localparam int ERR_EXP    = 31;
	localparam int MIN_EXP    = -23;

	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_POINT = 7'h2E;
	localparam logic [6:0] CH_NUL   = 7'h00;
	localparam logic [2:0] CH_DIGIT_HI = 3'b011;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DABBLE,
		ST_SIGN,
		ST_SKIP,
		ST_INT,
		ST_POINT,
		ST_FRAC,
		ST_ERR
	} step_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DABBLE,
		OP_SKIP,
		OP_SHIFT,
		OP_FRAC
	} op_t;

	typedef enum logic [2:0] {
		SEL_NUL,
		SEL_MINUS,
		SEL_BCD,
		SEL_POINT,
		SEL_FRAC
	} sel_t;

	typedef enum logic [1:0] {
		LAST_NONE,
		LAST_ALWAYS,
		LAST_NDIG0,
		LAST_NDIG1
	} last_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_ERR,
		C_CNT_MORE,
		C_SKIP_MORE,
		C_DCNT_MORE,
		C_NDIG_ZERO,
		C_NDIG_LAST
	} cond_t;

	typedef struct packed {
		op_t   op;
		logic  emit;
		logic  neg_only;
		logic  flag;
		sel_t  sel;
		last_t last;
		cond_t cond;
		step_t tgt_true;
		step_t tgt_false;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t cw;
		cw = '{OP_NONE, 1'b0, 1'b0, 1'b0, SEL_NUL, LAST_NONE, C_ALWAYS, ST_LOAD, ST_LOAD};
		case (step)
			ST_LOAD: cw = '{OP_LOAD, 1'b0, 1'b0, 1'b0, SEL_NUL, LAST_NONE,
				C_ERR, ST_ERR, ST_DABBLE};
			ST_DABBLE: cw = '{OP_DABBLE, 1'b0, 1'b0, 1'b0, SEL_NUL, LAST_NONE,
				C_CNT_MORE, ST_DABBLE, ST_SIGN};
			ST_SIGN: cw = '{OP_NONE, 1'b1, 1'b1, 1'b0, SEL_MINUS, LAST_NONE,
				C_NEVER, ST_SIGN, ST_SKIP};
			ST_SKIP: cw = '{OP_SKIP, 1'b0, 1'b0, 1'b0, SEL_NUL, LAST_NONE,
				C_SKIP_MORE, ST_SKIP, ST_INT};
			ST_INT: cw = '{OP_SHIFT, 1'b1, 1'b0, 1'b0, SEL_BCD, LAST_NONE,
				C_DCNT_MORE, ST_INT, ST_POINT};
			ST_POINT: cw = '{OP_NONE, 1'b1, 1'b0, 1'b0, SEL_POINT, LAST_NDIG0,
				C_NDIG_ZERO, ST_LOAD, ST_FRAC};
			ST_FRAC: cw = '{OP_FRAC, 1'b1, 1'b0, 1'b0, SEL_FRAC, LAST_NDIG1,
				C_NDIG_LAST, ST_LOAD, ST_FRAC};
			ST_ERR: cw = '{OP_NONE, 1'b1, 1'b0, 1'b1, SEL_NUL, LAST_ALWAYS,
				C_ALWAYS, ST_LOAD, ST_LOAD};
			default: cw = '{OP_NONE, 1'b0, 1'b0, 1'b0, SEL_NUL, LAST_NONE,
				C_ALWAYS, ST_LOAD, ST_LOAD};
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

FILE: design/float_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// float_to_decimal_text_unit
// prints a single-precision bit pattern as ascii decimal text, one char a beat
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one transaction per value: float bits and digit count.
//   m_* channel returns the characters of that value, tlast on the final one;
//   an exponent of 31 or more gives a single beat with tuser set and data 0.
// timing:
//   a microcoded step counter runs the value through a fixed program. after
//   the accept, a double-dabble loop turns the integer part into bcd, a sign
//   step handles the sign, the skip step drops leading zero digits (up to 9),
//   then one character leaves per cycle while the output is not stalled. a
//   too-large value goes from the load step straight to the error step. the
//   first character cannot leave before the double-dabble loop is done.
//   the next value is accepted when the program returns to its load step,
//   while the last character may still sit in the output register.
// stall:
//   a character step waits while the output register is full and not taken;
//   nothing is dropped. reset empties the output and returns to the load step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module float_to_decimal_text_unit #(
	parameter int MAX_FRACTION_DIGITS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,  // [31:0] float_bits, [35:32] fraction_digits
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,  // [6:0] text_char
	output      logic        m_tlast,  // is_last
	output      logic        m_tuser   // [0] too_large
);
	import ftdt_pkg::*;

	localparam int NW = $clog2(MAX_FRACTION_DIGITS + 1);
	localparam int CW = $clog2(INT_BITS + 1);
	localparam int DW = $clog2(BCD_DIGITS + 1);
	localparam int BW = 4 * BCD_DIGITS;

	step_t      upc_q, upc_d;
	ctrl_word_t cw;
	logic       step_go, cond_true, emit_en, out_free, s_fire;

	logic [INT_BITS-1:0]  ipart_q;
	logic [FRAC_BITS-1:0] fpart_q;
	logic [BW-1:0]        bcd_q, bcd_adj;
	logic [CW-1:0]        cnt_q;
	logic [DW-1:0]        dcnt_q;
	logic [NW-1:0]        ndig_q;
	logic                 neg_q;

	logic [6:0] char_q;
	logic       last_q, tuser_q, m_tvalid_q;

	// load-time decode
	logic [7:0]           exp_f;
	logic [23:0]          mant24;
	logic signed [9:0]    exp_unb, e_m23, e_p1, r23_me, neg_sh;
	logic                 load_err, load_neg;
	logic [INT_BITS-1:0]  ipart_ld;
	logic [FRAC_BITS-1:0] fpart_ld;
	logic [NW-1:0]        ndig_ld;

	logic [27:0] fprod;
	logic        skip_more;
	logic [6:0]  char_d;
	logic        last_d;

	assign exp_f    = s_tdata[30:23];
	assign mant24   = {1'b1, s_tdata[22:0]};
	assign exp_unb  = $signed({2'b00, exp_f}) - $signed(10'(EXP_BIAS));
	assign e_m23    = exp_unb - $signed(10'(MANT_BITS));
	assign e_p1     = exp_unb + 10'sd1;
	assign r23_me   = $signed(10'(MANT_BITS)) - exp_unb;
	assign neg_sh   = -e_p1;
	assign load_err = (exp_unb >= $signed(10'(ERR_EXP)));
	assign load_neg = s_tdata[31] && (s_tdata[30:0] != 31'd0);

	always_comb begin
		ipart_ld = '0;
		fpart_ld = '0;
		if (exp_unb >= $signed(10'(MANT_BITS))) begin
			ipart_ld = {7'd0, mant24} << e_m23[2:0];
		end else if (exp_unb >= 10'sd0) begin
			ipart_ld = {7'd0, mant24} >> r23_me[4:0];
			fpart_ld = mant24 << e_p1[4:0];
		end else if (exp_unb >= $signed(10'(MIN_EXP))) begin
			fpart_ld = mant24 >> neg_sh[4:0];
		end
		if (int'(s_tdata[35:32]) > MAX_FRACTION_DIGITS) begin
			ndig_ld = NW'(MAX_FRACTION_DIGITS);
		end else begin
			ndig_ld = NW'(s_tdata[35:32]);
		end
	end

	// add-3 correction of every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	assign fprod     = ({4'd0, fpart_q} << 3) + ({4'd0, fpart_q} << 1);
	assign skip_more = (bcd_q[BW-1 -: 4] == 4'd0) && (dcnt_q != DW'(1));

	// sequencer: control word, condition, stall and next step
	always_comb begin
		cw       = ucode_rom(upc_q);
		out_free = !m_tvalid_q || m_tready;
		emit_en  = cw.emit && (!cw.neg_only || neg_q);
		s_tready = (cw.op == OP_LOAD);
		s_fire   = s_tvalid && s_tready;
		step_go  = !((cw.op == OP_LOAD) && !s_tvalid) && !(emit_en && !out_free);
		case (cw.cond)
			C_NEVER:     cond_true = 1'b0;
			C_ALWAYS:    cond_true = 1'b1;
			C_ERR:       cond_true = load_err;
			C_CNT_MORE:  cond_true = (cnt_q != CW'(1));
			C_SKIP_MORE: cond_true = skip_more;
			C_DCNT_MORE: cond_true = (dcnt_q != DW'(1));
			C_NDIG_ZERO: cond_true = (ndig_q == NW'(0));
			C_NDIG_LAST: cond_true = (ndig_q == NW'(1));
			default:     cond_true = 1'b0;
		endcase
		upc_d = upc_q;
		if (step_go) begin
			upc_d = cond_true ? cw.tgt_true : cw.tgt_false;
		end
		case (cw.sel)
			SEL_MINUS: char_d = CH_MINUS;
			SEL_BCD:   char_d = {CH_DIGIT_HI, bcd_q[BW-1 -: 4]};
			SEL_POINT: char_d = CH_POINT;
			SEL_FRAC:  char_d = {CH_DIGIT_HI, fprod[27:24]};
			default:   char_d = CH_NUL;
		endcase
		case (cw.last)
			LAST_ALWAYS: last_d = 1'b1;
			LAST_NDIG0:  last_d = (ndig_q == NW'(0));
			LAST_NDIG1:  last_d = (ndig_q == NW'(1));
			default:     last_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_LOAD;
		end else begin
			upc_q <= upc_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (step_go) begin
			case (cw.op)
				OP_LOAD: begin
					ipart_q <= ipart_ld;
					fpart_q <= fpart_ld;
					ndig_q  <= ndig_ld;
					neg_q   <= load_neg;
					bcd_q   <= '0;
					cnt_q   <= CW'(INT_BITS);
					dcnt_q  <= DW'(BCD_DIGITS);
				end
				OP_DABBLE: begin
					bcd_q   <= {bcd_adj[BW-2:0], ipart_q[INT_BITS-1]};
					ipart_q <= {ipart_q[INT_BITS-2:0], 1'b0};
					cnt_q   <= cnt_q - CW'(1);
				end
				OP_SKIP: begin
					if (skip_more) begin
						bcd_q  <= {bcd_q[BW-5:0], 4'd0};
						dcnt_q <= dcnt_q - DW'(1);
					end
				end
				OP_SHIFT: begin
					bcd_q  <= {bcd_q[BW-5:0], 4'd0};
					dcnt_q <= dcnt_q - DW'(1);
				end
				OP_FRAC: begin
					fpart_q <= fprod[23:0];
					ndig_q  <= ndig_q - NW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step_go && emit_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && emit_en) begin
			char_q  <= char_d;
			last_q  <= last_d;
			tuser_q <= cw.flag;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;
	assign m_tuser  = tuser_q;

	`FTDT_ASSERT_IMP(a_err_beat, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0), "error beat must be last with null data")
	`FTDT_ASSERT_IMP(a_frac_digit, (upc_q == ST_FRAC), (fprod[27:24] <= 4'd9), "fraction digit out of range")
	`FTDT_ASSERT_IMP(a_bcd_digit, (upc_q == ST_INT), (bcd_q[BW-1 -: 4] <= 4'd9), "integer bcd digit out of range")
	`FTDT_ASSERT_NXT(a_err_branch, s_fire && load_err, (upc_q == ST_ERR), "too-large value did not branch to error step")

endmodule

`default_nettype wire
